/* rtl/necir_pkg.sv */
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, register map, reset values and helpers for the NEC infrared
// edge decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

	// frame geometry
	localparam int CODE_BITS = 32;
	localparam int CODE_W    = 32;
	localparam int IDX_W     = 5;
	localparam int CNT_W     = 6;
	localparam int TIME_W    = 32;
	localparam int REG_W     = 16;

	// configuration register file
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_START_MIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_START_MAX  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX  = 3'd7;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd8000, 16'd10000, 16'd1700, 16'd2800,
		16'd3500, 16'd5500,  16'd400,  16'd750
	};

	// fixed window for a one-bit (long) space
	localparam logic [TIME_W-1:0] LONG_SPACE_MIN_US = 32'd1500;
	localparam logic [TIME_W-1:0] LONG_SPACE_MAX_US = 32'd1700;

	// event kinds on the result channel
	localparam logic EV_FULL   = 1'b0;
	localparam logic EV_REPEAT = 1'b1;

	// decoder phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEADER = 3'd1,
		PH_SPACE  = 3'd2,
		PH_MARK   = 3'd3,
		PH_REPEAT = 3'd4
	} phase_t;

	// inclusive window check of a duration against two 16-bit bounds
	function automatic logic in_window(
		input logic [TIME_W-1:0] d,
		input logic [REG_W-1:0]  lo,
		input logic [REG_W-1:0]  hi
	);
		logic ge_lo;
		logic le_hi;
		ge_lo = {{(TIME_W-REG_W){1'b0}}, lo} <= d;
		le_hi = d <= {{(TIME_W-REG_W){1'b0}}, hi};
		return ge_lo && le_hi;
	endfunction

endpackage

/* rtl/nec_ir_edge_decoder_core.sv */
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_core
// Decodes NEC infrared frames from timestamped receiver pin samples and emits
// full-code and repeat events.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata[31:0] time_us, [32] pin_level
// m_axis    out  tvalid/tready             tdata[31:0] code, tuser event_kind
// apb       in   psel/penable/pwrite/pready 8 x 16-bit window bounds (4 min/max pairs)
//
// one sample per clock sustained unless a result stalls; an accepted sample
// reaches its result through the input register, then the result register
// the duration subtract and window compares sit between those two registers
// reset clears handshake state, decoder state and restores the default windows
// a stalled result holds in the result register and the input register stops
// moving; tready drops while the input register holds a sample during that stall
module nec_ir_edge_decoder_core
	import necir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// sample stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [39:0]          s_axis_tdata,   // [31:0] time_us, [32] pin_level, rest zero
	// event stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [CODE_W-1:0]    m_axis_tdata,   // [31:0] code
	output logic                 m_axis_tuser,   // [0] event_kind
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	// configuration registers
	logic [REG_W-1:0] cfg_q [NUM_REGS];
	logic             cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_wr) begin
			cfg_q[cfg_idx] <= pwdata[REG_W-1:0];
		end
	end

	assign prdata = {{(PDATA_W-REG_W){1'b0}}, cfg_q[cfg_idx]};

	// input register
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              level_s1;
	logic              adv;
	logic              fire;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign fire          = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			time_s1  <= s_axis_tdata[TIME_W-1:0];
			level_s1 <= s_axis_tdata[TIME_W];
		end
	end

	// decoder state
	logic [TIME_W-1:0] last_q;
	logic              mark_q;
	phase_t            phase_q;
	logic [CODE_W-1:0] code_q;
	logic [CNT_W-1:0]  cnt_q;

	// duration of the level that just ended and window hits
	logic              mark_now;
	logic              changed;
	logic [TIME_W-1:0] dur;
	logic              hit_leader;
	logic              hit_repeat;
	logic              hit_start;
	logic              hit_short;
	logic              hit_long;
	logic              bits_left;

	assign mark_now   = ~level_s1;
	assign changed    = mark_now != mark_q;
	assign dur        = time_s1 - last_q;
	assign hit_leader = in_window(dur, cfg_q[REG_LEADER_MIN], cfg_q[REG_LEADER_MAX]);
	assign hit_repeat = in_window(dur, cfg_q[REG_REPEAT_MIN], cfg_q[REG_REPEAT_MAX]);
	assign hit_start  = in_window(dur, cfg_q[REG_START_MIN], cfg_q[REG_START_MAX]);
	assign hit_short  = in_window(dur, cfg_q[REG_SHORT_MIN], cfg_q[REG_SHORT_MAX]);
	assign hit_long   = (LONG_SPACE_MIN_US <= dur) && (dur <= LONG_SPACE_MAX_US);
	assign bits_left  = cnt_q < CNT_W'(CODE_BITS);

	// next state
	phase_t            phase_d;
	logic [CODE_W-1:0] code_d;
	logic [CNT_W-1:0]  cnt_d;

	always_comb begin
		phase_d = phase_q;
		code_d  = code_q;
		cnt_d   = cnt_q;
		if (changed) begin
			if (!mark_now && hit_leader) begin
				phase_d = PH_LEADER;
			end else begin
				unique case (phase_q)
					PH_LEADER: begin
						if (mark_now && hit_repeat) begin
							phase_d = PH_REPEAT;
						end else if (mark_now && hit_start) begin
							phase_d = PH_SPACE;
							code_d  = '0;
							cnt_d   = '0;
						end
					end
					PH_SPACE: begin
						if (!mark_now && hit_short) begin
							phase_d = bits_left ? PH_MARK : PH_IDLE;
						end
					end
					PH_MARK: begin
						if (mark_now && hit_short) begin
							phase_d = PH_SPACE;
							cnt_d   = cnt_q + CNT_W'(1);
						end else if (mark_now && hit_long) begin
							phase_d = PH_SPACE;
							if (cnt_q < CNT_W'(CODE_W)) begin
								code_d = code_q | (CODE_W'(1) << cnt_q[IDX_W-1:0]);
							end
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// event outputs
	logic ev_valid;
	logic ev_kind;

	always_comb begin
		ev_valid = 1'b0;
		ev_kind  = EV_FULL;
		if (changed && !(!mark_now && hit_leader)) begin
			unique case (phase_q)
				PH_REPEAT: begin
					if (!mark_now && hit_short) begin
						ev_valid = 1'b1;
						ev_kind  = EV_REPEAT;
					end
				end
				PH_SPACE: begin
					if (!mark_now && hit_short && !bits_left) begin
						ev_valid = 1'b1;
						ev_kind  = EV_FULL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// state update when the sample in the input register is consumed and changes level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			mark_q  <= 1'b0;
			phase_q <= PH_IDLE;
			code_q  <= '0;
			cnt_q   <= '0;
		end else if (fire && changed) begin
			last_q  <= time_s1;
			mark_q  <= mark_now;
			phase_q <= phase_d;
			code_q  <= code_d;
			cnt_q   <= cnt_d;
		end
	end

	// result register
	logic res_load;

	assign res_load = fire && ev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_axis_tdata <= code_q;
			m_axis_tuser <= ev_kind;
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CODE_BITS))
		else $error("bit count beyond frame length");

	a_full_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && ev_kind == EV_FULL |=> phase_q == PH_IDLE)
		else $error("full code did not return decoder to idle");

	a_event_on_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> level_s1 && changed)
		else $error("event raised on a sample that did not end a mark");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(time_s1) && $stable(level_s1))
		else $error("input register lost a waiting sample");

	a_repeat_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && ev_kind == EV_REPEAT |-> phase_q == PH_REPEAT)
		else $error("repeat event outside repeat phase");

endmodule
